// File: hw/rtl/led_raindrop_effect_top_assert.svh
// assertion macros for the raindrop block
`ifndef LED_RAINDROP_EFFECT_TOP_ASSERT_SVH
`define LED_RAINDROP_EFFECT_TOP_ASSERT_SVH

// same-cycle implication
`define LRD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LRD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/lrd_pkg.sv
package lrd_pkg;

   localparam int HUE_W = 9;
   localparam int VAL_W = 16;

   // one word of the per-led store
   typedef struct packed {
      logic [HUE_W-1:0] hue;
      logic [VAL_W-1:0] sat;
      logic [VAL_W-1:0] bright;
      logic [VAL_W-1:0] decay;
   } led_type;

   localparam int LED_W = $bits(led_type);

   typedef enum logic [2:0] {
      CSR_HUE_LOW       = 3'd0,
      CSR_HUE_HIGH      = 3'd1,
      CSR_SAT_LOW       = 3'd2,
      CSR_SAT_HIGH      = 3'd3,
      CSR_BRIGHT_LOW    = 3'd4,
      CSR_BRIGHT_HIGH   = 3'd5,
      CSR_STRIKE_CHANCE = 3'd6,
      CSR_DECAY_BOUNDS  = 3'd7
   } csr_reg_type;

   localparam logic [HUE_W-1:0] HUE_LOW_RST       = 9'd0;
   localparam logic [HUE_W-1:0] HUE_HIGH_RST      = 9'd360;
   localparam logic [VAL_W-1:0] SAT_LOW_RST       = 16'd0;
   localparam logic [VAL_W-1:0] SAT_HIGH_RST      = 16'd65535;
   localparam logic [VAL_W-1:0] BRIGHT_LOW_RST    = 16'd52429;
   localparam logic [VAL_W-1:0] BRIGHT_HIGH_RST   = 16'd65535;
   localparam logic [VAL_W-1:0] STRIKE_CHANCE_RST = 16'd62259;
   localparam logic [31:0]      DECAY_BOUNDS_RST  = 32'h8000_CCCD;

endpackage

// File: hw/rtl/lrd_ram.sv
module lrd_ram #(
   parameter int WIDTH = 57,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old word on a same-address write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/lrd_map.sv
module lrd_map #(
   parameter int W = 16
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] lo,
   input  logic [W-1:0] hi,
   input  logic [15:0]  rnd,
   output logic [W-1:0] lo_q,
   output logic [W-1:0] step_q,
   output logic         rev_q
);

   logic         rev_in;
   logic [W-1:0] span_in;
   logic [W+15:0] prod_in;
   logic [W-1:0] lo_ff;
   logic [W-1:0] step_ff;
   logic         rev_ff;

   // span times random word, keep the upper part
   always_comb begin
      rev_in  = hi < lo;
      span_in = rev_in ? (lo - hi) : (hi - lo);
      prod_in = {{W{1'b0}}, rnd} * {16'd0, span_in};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lo_ff   <= lo;
         step_ff <= prod_in[W+15:16];
         rev_ff  <= rev_in;
      end
   end

   assign lo_q   = lo_ff;
   assign step_q = step_ff;
   assign rev_q  = rev_ff;

endmodule

// File: hw/rtl/led_raindrop_effect_top.sv
// channel | dir | handshake             | payload
// req     | in  | req_tvalid/req_tready | req_tdata: led_index, roll, rand_hue/sat/bright/decay
// rsp     | out | rsp_tvalid/rsp_tready | rsp_tdata: hue, sat, bright; rsp_tuser: struck
// csr     | in  | csr_valid/csr_ready   | csr_index, csr_data
//
// one word per cycle while rsp does not stall and the clearing pass is done
// stages: range multiply and store read, map add and forward, decay multiply and write back
// after reset a clearing pass zeroes every store address in turn with req_tready low
// a stall on rsp freezes every stage, including the store ports
module led_raindrop_effect_top #(
   parameter int NUM_LEDS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [87:0] req_tdata,   // led_index, roll, rand_hue, rand_sat, rand_bright, rand_decay
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // hue_out, sat_out, bright_out, zero fill
   output logic        rsp_tuser,   // struck
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int AW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
   localparam int HW = lrd_pkg::HUE_W;
   localparam int VW = lrd_pkg::VAL_W;

   // configuration
   logic [HW-1:0] hue_low_ff, hue_high_ff;
   logic [VW-1:0] sat_low_ff, sat_high_ff, bright_low_ff, bright_high_ff;
   logic [VW-1:0] strike_chance_ff;
   logic [31:0]   decay_bounds_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hue_low_ff       <= lrd_pkg::HUE_LOW_RST;
         hue_high_ff      <= lrd_pkg::HUE_HIGH_RST;
         sat_low_ff       <= lrd_pkg::SAT_LOW_RST;
         sat_high_ff      <= lrd_pkg::SAT_HIGH_RST;
         bright_low_ff    <= lrd_pkg::BRIGHT_LOW_RST;
         bright_high_ff   <= lrd_pkg::BRIGHT_HIGH_RST;
         strike_chance_ff <= lrd_pkg::STRIKE_CHANCE_RST;
         decay_bounds_ff  <= lrd_pkg::DECAY_BOUNDS_RST;
      end else if (csr_valid && csr_ready) begin
         case (lrd_pkg::csr_reg_type'(csr_index))
            lrd_pkg::CSR_HUE_LOW:       hue_low_ff       <= csr_data[HW-1:0];
            lrd_pkg::CSR_HUE_HIGH:      hue_high_ff      <= csr_data[HW-1:0];
            lrd_pkg::CSR_SAT_LOW:       sat_low_ff       <= csr_data[VW-1:0];
            lrd_pkg::CSR_SAT_HIGH:      sat_high_ff      <= csr_data[VW-1:0];
            lrd_pkg::CSR_BRIGHT_LOW:    bright_low_ff    <= csr_data[VW-1:0];
            lrd_pkg::CSR_BRIGHT_HIGH:   bright_high_ff   <= csr_data[VW-1:0];
            lrd_pkg::CSR_STRIKE_CHANCE: strike_chance_ff <= csr_data[VW-1:0];
            lrd_pkg::CSR_DECAY_BOUNDS:  decay_bounds_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // input word
   logic [7:0]  led_index;
   logic [15:0] roll, rand_hue, rand_sat, rand_bright, rand_decay;

   assign led_index   = req_tdata[7:0];
   assign roll        = req_tdata[23:8];
   assign rand_hue    = req_tdata[39:24];
   assign rand_sat    = req_tdata[55:40];
   assign rand_bright = req_tdata[71:56];
   assign rand_decay  = req_tdata[87:72];

   // flow control
   logic advance, accept;
   logic v1_ff, v2_ff, v3_ff;
   logic clr_busy_ff;
   logic [AW-1:0] clr_addr_ff;

   assign advance    = !v3_ff || rsp_tready;
   assign req_tready = advance && !clr_busy_ff;
   assign accept     = req_tvalid && req_tready;

   // clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == AW'(NUM_LEDS - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // stage 1: range products, hit, store read
   logic [HW-1:0] hue_lo, hue_step;
   logic [VW-1:0] sat_lo, sat_step, bri_lo, bri_step, dec_lo, dec_step;
   logic          hue_rev, sat_rev, bri_rev, dec_rev;
   logic [16:0]   hit_sum;
   logic [AW-1:0] addr1_ff;
   logic          inr1_ff, hit1_ff;

   lrd_map #(.W(HW)) u_map_hue (
      .clock(clock), .en(advance), .lo(hue_low_ff), .hi(hue_high_ff), .rnd(rand_hue),
      .lo_q(hue_lo), .step_q(hue_step), .rev_q(hue_rev));
   lrd_map #(.W(VW)) u_map_sat (
      .clock(clock), .en(advance), .lo(sat_low_ff), .hi(sat_high_ff), .rnd(rand_sat),
      .lo_q(sat_lo), .step_q(sat_step), .rev_q(sat_rev));
   lrd_map #(.W(VW)) u_map_bri (
      .clock(clock), .en(advance), .lo(bright_low_ff), .hi(bright_high_ff),
      .rnd(rand_bright), .lo_q(bri_lo), .step_q(bri_step), .rev_q(bri_rev));
   lrd_map #(.W(VW)) u_map_dec (
      .clock(clock), .en(advance), .lo(decay_bounds_ff[15:0]),
      .hi(decay_bounds_ff[31:16]), .rnd(rand_decay),
      .lo_q(dec_lo), .step_q(dec_step), .rev_q(dec_rev));

   assign hit_sum = {1'b0, roll} + {1'b0, strike_chance_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         addr1_ff <= AW'(led_index);
         inr1_ff  <= {24'd0, led_index} < 32'(NUM_LEDS);
         hit1_ff  <= hit_sum[16];
      end
   end

   // store
   logic                      ram_we;
   logic [AW-1:0]             ram_waddr;
   logic [lrd_pkg::LED_W-1:0] ram_wdata, ram_rdata;

   lrd_ram #(.WIDTH(lrd_pkg::LED_W), .DEPTH(NUM_LEDS)) u_store (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_waddr), .wr_data(ram_wdata),
      .rd_en(advance), .rd_addr(AW'(led_index)), .rd_data(ram_rdata));

   // stage 2 registers and write-back path
   logic [AW-1:0]    addr2_ff;
   logic             inr2_ff, hit2_ff;
   lrd_pkg::led_type led2_ff, led2_in, wr_led, old_led;
   logic [31:0]      decay_prod;
   logic             wb_v_ff;
   logic [AW-1:0]    wb_addr_ff;
   lrd_pkg::led_type wb_led_ff;

   always_comb begin
      decay_prod    = {16'd0, led2_ff.bright} * {16'd0, led2_ff.decay};
      wr_led        = led2_ff;
      wr_led.bright = decay_prod[31:16];
   end

   assign ram_we    = clr_busy_ff || (v2_ff && inr2_ff && advance);
   assign ram_waddr = clr_busy_ff ? clr_addr_ff : addr2_ff;
   assign ram_wdata = clr_busy_ff ? '0 : wr_led;

   // stage 1 logic: forward writes the store read missed, then map or keep
   always_comb begin
      if (v2_ff && inr2_ff && addr2_ff == addr1_ff) begin
         old_led = wr_led;
      end else if (wb_v_ff && wb_addr_ff == addr1_ff) begin
         old_led = wb_led_ff;
      end else begin
         old_led = lrd_pkg::led_type'(ram_rdata);
      end
      if (hit1_ff) begin
         led2_in.hue    = hue_rev ? (hue_lo - hue_step) : (hue_lo + hue_step);
         led2_in.sat    = sat_rev ? (sat_lo - sat_step) : (sat_lo + sat_step);
         led2_in.bright = bri_rev ? (bri_lo - bri_step) : (bri_lo + bri_step);
         led2_in.decay  = dec_rev ? (dec_lo - dec_step) : (dec_lo + dec_step);
      end else begin
         led2_in = old_led;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff   <= 1'b0;
         wb_v_ff <= 1'b0;
      end else if (advance) begin
         v2_ff   <= v1_ff;
         wb_v_ff <= v2_ff && inr2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         addr2_ff   <= addr1_ff;
         inr2_ff    <= inr1_ff;
         hit2_ff    <= hit1_ff;
         led2_ff    <= led2_in;
         wb_addr_ff <= addr2_ff;
         wb_led_ff  <= wr_led;
      end
   end

   // stage 3: result register
   logic [HW-1:0] hue3_ff;
   logic [VW-1:0] sat3_ff, bri3_ff;
   logic          struck3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (advance) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         hue3_ff    <= inr2_ff ? led2_ff.hue : '0;
         sat3_ff    <= inr2_ff ? led2_ff.sat : '0;
         bri3_ff    <= inr2_ff ? led2_ff.bright : '0;
         struck3_ff <= inr2_ff && hit2_ff;
      end
   end

   assign rsp_tvalid = v3_ff;
   assign rsp_tdata  = {7'd0, bri3_ff, sat3_ff, hue3_ff};
   assign rsp_tuser  = struck3_ff;

`include "led_raindrop_effect_top_assert.svh"

   `LRD_ASSERT_NOW(a_clear_leaves_empty, $fell(clr_busy_ff), !v1_ff && !v2_ff && !v3_ff, "pipeline not empty after clearing pass")
   `LRD_ASSERT_NEXT(a_stage_moves, advance && v2_ff, v3_ff, "word lost between decay and result stage")
   `LRD_ASSERT_NOW(a_decay_shrinks, v2_ff && inr2_ff, wr_led.bright <= led2_ff.bright, "decayed brightness grew")

endmodule

// File: verif/tb.sv
module tb;

   localparam int LEDS       = 256;
   localparam int N_DIRECTED = 19;
   localparam int N_PHASES   = 7;
   localparam int PHASE_LEN  = 62;
   localparam int HOLD_LEN   = 300;

   typedef struct packed {
      logic [7:0]  led;
      logic [15:0] roll;
      logic [15:0] rand_hue;
      logic [15:0] rand_sat;
      logic [15:0] rand_bright;
      logic [15:0] rand_decay;
   } drop_type;

   typedef struct packed {
      logic [8:0]  hue;
      logic [15:0] sat;
      logic [15:0] bright;
      logic        struck;
   } color_type;

   typedef struct packed {
      logic      typed;
      drop_type  drop;
      color_type color;
   } drop_row_type;

   // typed rows: untouched leds, a roll one short of a strike, a strike with all words zero
   localparam drop_row_type DIRECTED [N_DIRECTED] = '{
      '{1'b1, '{8'd0,   16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
         '{9'd0, 16'd0, 16'd0, 1'b0}},
      '{1'b1, '{8'd255, 16'd3276, 16'hffff, 16'hffff, 16'hffff, 16'hffff},
         '{9'd0, 16'd0, 16'd0, 1'b0}},
      '{1'b1, '{8'd255, 16'd3277, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
         '{9'd0, 16'd0, 16'd52429, 1'b1}},
      '{1'b0, '{8'd255, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, '0},
      '{1'b0, '{8'd255, 16'h0000, 16'hffff, 16'hffff, 16'hffff, 16'hffff}, '0},
      '{1'b0, '{8'd0,   16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff}, '0},
      '{1'b0, '{8'd0,   16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, '0},
      '{1'b0, '{8'd0,   16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, '0},
      '{1'b0, '{8'd1,   16'hffff, 16'h8000, 16'h8000, 16'h8000, 16'h8000}, '0},
      '{1'b0, '{8'd1,   16'h1234, 16'h1111, 16'h2222, 16'h3333, 16'h4444}, '0},
      '{1'b0, '{8'd128, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555}, '0},
      '{1'b0, '{8'd128, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa}, '0},
      '{1'b0, '{8'h55,  16'hffff, 16'h0f0f, 16'hf0f0, 16'h00ff, 16'hff00}, '0},
      '{1'b0, '{8'haa,  16'hfffe, 16'hf0f0, 16'h0f0f, 16'hff00, 16'h00ff}, '0},
      '{1'b0, '{8'h55,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, '0},
      '{1'b0, '{8'haa,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, '0},
      '{1'b1, '{8'd2,   16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
         '{9'd0, 16'd0, 16'd0, 1'b0}},
      '{1'b0, '{8'd255, 16'hffff, 16'h1234, 16'h5678, 16'h9abc, 16'hdef0}, '0},
      '{1'b0, '{8'd255, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, '0}
   };

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [87:0] req_tdata  = '0;   // led_index, roll, rand_hue, rand_sat, rand_bright, rand_decay
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;         // hue_out, sat_out, bright_out, zero fill
   logic        rsp_tuser;         // struck
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   lrd_pkg::csr_reg_type csr_index = lrd_pkg::CSR_HUE_LOW;
   logic [31:0] csr_data   = '0;

   logic        quiet        = 1'b0;
   int          results_seen = 0;
   int          mismatches   = 0;

   color_type   pending_colors[$];

   // predictor copy of the block
   logic [8:0]  hue_lo_r, hue_hi_r;
   logic [15:0] sat_lo_r, sat_hi_r, bright_lo_r, bright_hi_r, chance_r;
   logic [31:0] decay_bounds_r;
   logic [8:0]  hue_mem    [LEDS];
   logic [15:0] sat_mem    [LEDS];
   logic [15:0] bright_mem [LEDS];
   logic [15:0] decay_mem  [LEDS];

   led_raindrop_effect_top #(.NUM_LEDS(LEDS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #400000;
      $display("Simulation FAILED");
      $finish;
   end

   // lo + r*(hi-lo)/65536, or lo - r*(lo-hi)/65536 when the bounds are reversed
   function automatic logic [31:0] scale_into(input logic [31:0] lo, input logic [31:0] hi,
                                              input logic [15:0] r);
      logic [63:0] prod;
      if (hi >= lo) begin
         prod = {48'd0, r} * {32'd0, hi - lo};
         return lo + prod[47:16];
      end
      prod = {48'd0, r} * {32'd0, lo - hi};
      return lo - prod[47:16];
   endfunction

   function automatic void clear_model();
      hue_lo_r       = lrd_pkg::HUE_LOW_RST;
      hue_hi_r       = lrd_pkg::HUE_HIGH_RST;
      sat_lo_r       = lrd_pkg::SAT_LOW_RST;
      sat_hi_r       = lrd_pkg::SAT_HIGH_RST;
      bright_lo_r    = lrd_pkg::BRIGHT_LOW_RST;
      bright_hi_r    = lrd_pkg::BRIGHT_HIGH_RST;
      chance_r       = lrd_pkg::STRIKE_CHANCE_RST;
      decay_bounds_r = lrd_pkg::DECAY_BOUNDS_RST;
      for (int i = 0; i < LEDS; i++) begin
         hue_mem[i]    = '0;
         sat_mem[i]    = '0;
         bright_mem[i] = '0;
         decay_mem[i]  = '0;
      end
   endfunction

   function automatic void apply_csr(input lrd_pkg::csr_reg_type idx, input logic [31:0] v);
      case (idx)
         lrd_pkg::CSR_HUE_LOW:       hue_lo_r       = v[8:0];
         lrd_pkg::CSR_HUE_HIGH:      hue_hi_r       = v[8:0];
         lrd_pkg::CSR_SAT_LOW:       sat_lo_r       = v[15:0];
         lrd_pkg::CSR_SAT_HIGH:      sat_hi_r       = v[15:0];
         lrd_pkg::CSR_BRIGHT_LOW:    bright_lo_r    = v[15:0];
         lrd_pkg::CSR_BRIGHT_HIGH:   bright_hi_r    = v[15:0];
         lrd_pkg::CSR_STRIKE_CHANCE: chance_r       = v[15:0];
         lrd_pkg::CSR_DECAY_BOUNDS:  decay_bounds_r = v;
         default: ;
      endcase
   endfunction

   function automatic void advance_led(input drop_type d, output color_type c);
      logic [16:0] sum;
      logic        hit;
      logic [31:0] mapped;
      logic [31:0] prod;
      sum = {1'b0, d.roll} + {1'b0, chance_r};
      hit = sum[16];
      if (hit) begin
         mapped = scale_into({23'd0, hue_lo_r}, {23'd0, hue_hi_r}, d.rand_hue);
         hue_mem[d.led] = mapped[8:0];
         mapped = scale_into({16'd0, sat_lo_r}, {16'd0, sat_hi_r}, d.rand_sat);
         sat_mem[d.led] = mapped[15:0];
         mapped = scale_into({16'd0, bright_lo_r}, {16'd0, bright_hi_r}, d.rand_bright);
         bright_mem[d.led] = mapped[15:0];
         mapped = scale_into({16'd0, decay_bounds_r[15:0]}, {16'd0, decay_bounds_r[31:16]},
                             d.rand_decay);
         decay_mem[d.led] = mapped[15:0];
      end
      c.hue    = hue_mem[d.led];
      c.sat    = sat_mem[d.led];
      c.bright = bright_mem[d.led];
      c.struck = hit;
      prod = {16'd0, bright_mem[d.led]} * {16'd0, decay_mem[d.led]};
      bright_mem[d.led] = prod[31:16];
   endfunction

   function automatic logic [15:0] rand_word();
      case ($urandom_range(0, 7))
         0:       return 16'h0000;
         1:       return 16'hffff;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // mostly a handful of leds so that strikes and decay chains pile up on the same entry
   function automatic drop_type make_drop();
      drop_type d;
      if ($urandom_range(0, 3) == 0)
         d.led = 8'($urandom_range(0, 255));
      else
         d.led = 8'($urandom_range(0, 7));
      d.roll        = rand_word();
      d.rand_hue    = rand_word();
      d.rand_sat    = rand_word();
      d.rand_bright = rand_word();
      d.rand_decay  = rand_word();
      return d;
   endfunction

   task automatic send_drop(input drop_type d, input logic typed, input color_type typed_color);
      color_type c;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {d.rand_decay, d.rand_bright, d.rand_sat, d.rand_hue, d.roll, d.led};
      do @(posedge clock); while (!req_tready);
      advance_led(d, c);
      pending_colors.push_back(typed ? typed_color : c);
   endtask

   task automatic csr_write(input lrd_pkg::csr_reg_type idx, input logic [31:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      apply_csr(idx, v);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_colors.size() != 0) @(negedge clock);
      @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic void check_field(input string name, input logic [15:0] exp_v,
                                       input logic [15:0] got_v);
      if (exp_v !== got_v) begin
         $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, exp_v, got_v);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      color_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen <= results_seen + 1;
         if (pending_colors.size() == 0) begin
            $display("%0t unexpected word: expected none, actual %h/%b", $time, rsp_tdata,
                     rsp_tuser);
            mismatches++;
         end else begin
            e = pending_colors.pop_front();
            check_field("hue", {7'd0, e.hue}, {7'd0, rsp_tdata[8:0]});
            check_field("sat", e.sat, rsp_tdata[24:9]);
            check_field("bright", e.bright, rsp_tdata[40:25]);
            check_field("struck", {15'd0, e.struck}, {15'd0, rsp_tuser});
         end
      end
   end

   // receiver: random stalls, plus one long hold-off so the pipe backs up into req
   initial begin
      logic held;
      held = 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (!held && results_seen >= 60) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_LEN) @(posedge clock);
            held = 1'b1;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin
      logic [31:0] vals [8];
      clear_model();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int k = 0; k < N_DIRECTED; k++)
         send_drop(DIRECTED[k].drop, DIRECTED[k].typed, DIRECTED[k].color);

      for (int ph = 0; ph < N_PHASES; ph++) begin
         case (ph)
            // never strikes: only decay of what is stored
            0: vals = '{32'd0, 32'd360, 32'd0, 32'd65535, 32'd0, 32'd65535, 32'd0, 32'h0000_0000};
            // reversed bounds everywhere, strikes on any nonzero roll
            1: vals = '{32'd360, 32'd0, 32'd65535, 32'd0, 32'd65535, 32'd0, 32'd65535,
                        32'h0000_ffff};
            // hue bounds above 360
            2: vals = '{32'd511, 32'd400, 32'd100, 32'd60000, 32'd1000, 32'd65535, 32'd32768,
                        32'hffff_0000};
            5: vals = '{default: 32'hffff_ffff};
            6: vals = '{32'(lrd_pkg::HUE_LOW_RST), 32'(lrd_pkg::HUE_HIGH_RST),
                        32'(lrd_pkg::SAT_LOW_RST), 32'(lrd_pkg::SAT_HIGH_RST),
                        32'(lrd_pkg::BRIGHT_LOW_RST), 32'(lrd_pkg::BRIGHT_HIGH_RST),
                        32'(lrd_pkg::STRIKE_CHANCE_RST), lrd_pkg::DECAY_BOUNDS_RST};
            default: for (int r = 0; r < 8; r++) vals[r] = $urandom();
         endcase
         drain();
         if (ph == N_PHASES - 1)
            quiet <= 1'b1;
         for (int r = 0; r < 8; r++)
            csr_write(lrd_pkg::csr_reg_type'(r), vals[r]);
         csr_valid <= 1'b0;
         for (int n = 0; n < PHASE_LEN; n++)
            send_drop(make_drop(), 1'b0, '0);
      end

      drain();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && pending_colors.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/lrd_pkg.sv
hw/rtl/lrd_ram.sv
hw/rtl/lrd_map.sv
hw/rtl/led_raindrop_effect_top.sv
verif/tb.sv
